// ----- design/dlle_pkg.sv -----
// Shared types, codes and the microcode program of the doubly linked list engine.
package dlle_pkg;

    // Default sizes of the node pool and of one stored item.
    localparam int NODE_COUNT_DEF = 1024;
    localparam int ITEM_BITS_DEF  = 32;

    // Fixed widths of the channel fields.
    localparam int CMD_W    = 3;
    localparam int IN_IDX_W = 10;
    localparam int PAY_W    = 32;
    localparam int STAT_W   = 2;
    localparam int UPC_W    = 5;

    // Command codes.
    typedef enum logic [CMD_W-1:0] {
        CMD_INIT     = 3'd0,
        CMD_INS_HEAD = 3'd1,
        CMD_INS_TAIL = 3'd2,
        CMD_POP_HEAD = 3'd3,
        CMD_POP_TAIL = 3'd4,
        CMD_REM_NODE = 3'd5,
        CMD_REM_SECT = 3'd6
    } t_cmd;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY   = 2'd1;
    localparam logic [STAT_W-1:0] ST_REFUSED = 2'd2;

    // One input item.
    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [IN_IDX_W-1:0] list_head;
        logic [IN_IDX_W-1:0] node_index;
        logic [IN_IDX_W-1:0] section_end;
        logic [PAY_W-1:0]    payload;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic [PAY_W-1:0]    item_out;
        logic [IN_IDX_W-1:0] node_out;
        logic [STAT_W-1:0]   status;
    } t_out_item;

    // Operand sources of the datapath: held indices, link registers and read data.
    typedef enum logic [2:0] {
        SRC_H   = 3'd0,
        SRC_N   = 3'd1,
        SRC_E   = 3'd2,
        SRC_A   = 3'd3,
        SRC_B   = 3'd4,
        SRC_FRD = 3'd5,
        SRC_BRD = 3'd6
    } t_src;

    // How the final step forms the result item.
    typedef enum logic [2:0] {
        RES_NONE   = 3'd0,
        RES_POP    = 3'd1,
        RES_REM    = 3'd2,
        RES_EMPTY  = 3'd3,
        RES_REFUSE = 3'd4
    } t_res;

    typedef logic [UPC_W-1:0] t_upc;

    // One control word of the program.
    typedef struct packed {
        t_src fr_addr;
        t_src br_addr;
        t_src ir_addr;
        logic fw_en;
        t_src fw_addr;
        t_src fw_data;
        logic bw_en;
        t_src bw_addr;
        t_src bw_data;
        logic iw_en;
        logic ld_a;
        t_src a_src;
        logic ld_b;
        t_src b_src;
        logic item_cap;
        logic jmp_en;
        t_src cmp_src;
        t_upc jmp_to;
        logic done;
        t_res res;
    } t_ctl;

    // Status returned by the datapath to the sequencer.
    typedef struct packed {
        logic src_eq;
    } t_dp_stat;

    // Control word that does nothing.
    localparam t_ctl CTL_NOP = '0;

    // Program addresses.
    localparam t_upc UPC_INIT   = 5'd0;
    localparam t_upc UPC_INSH0  = 5'd1;
    localparam t_upc UPC_INSH1  = 5'd2;
    localparam t_upc UPC_INSH2  = 5'd3;
    localparam t_upc UPC_INST0  = 5'd4;
    localparam t_upc UPC_INST1  = 5'd5;
    localparam t_upc UPC_INST2  = 5'd6;
    localparam t_upc UPC_POPH0  = 5'd7;
    localparam t_upc UPC_POPH1  = 5'd8;
    localparam t_upc UPC_POPH2  = 5'd9;
    localparam t_upc UPC_POPH3  = 5'd10;
    localparam t_upc UPC_POPT0  = 5'd11;
    localparam t_upc UPC_POPT1  = 5'd12;
    localparam t_upc UPC_POPT2  = 5'd13;
    localparam t_upc UPC_POPT3  = 5'd14;
    localparam t_upc UPC_REM0   = 5'd15;
    localparam t_upc UPC_REM1   = 5'd16;
    localparam t_upc UPC_REM2   = 5'd17;
    localparam t_upc UPC_REM3   = 5'd18;
    localparam t_upc UPC_SEC0   = 5'd19;
    localparam t_upc UPC_SEC1   = 5'd20;
    localparam t_upc UPC_EMPTY  = 5'd21;
    localparam t_upc UPC_REFUSE = 5'd22;
    localparam t_upc UPC_NOP    = 5'd23;

    // Entry point of each command.
    function automatic t_upc entry_point(input logic [CMD_W-1:0] cmd);
        t_upc pc;
        case (cmd)
            CMD_INIT:     pc = UPC_INIT;
            CMD_INS_HEAD: pc = UPC_INSH0;
            CMD_INS_TAIL: pc = UPC_INST0;
            CMD_POP_HEAD: pc = UPC_POPH0;
            CMD_POP_TAIL: pc = UPC_POPT0;
            CMD_REM_NODE: pc = UPC_REM0;
            CMD_REM_SECT: pc = UPC_SEC0;
            default:      pc = UPC_NOP;
        endcase
        return pc;
    endfunction

    // The program. Memory reads are registered; a step that can jump does no writes,
    // so that a refused or empty command leaves the links as they were.
    function automatic t_ctl ucode(input t_upc pc);
        t_ctl c;
        c = CTL_NOP;
        case (pc)
            // Init: the sentinel links to itself.
            UPC_INIT: begin
                c.fw_en = 1'b1; c.fw_addr = SRC_H; c.fw_data = SRC_H;
                c.bw_en = 1'b1; c.bw_addr = SRC_H; c.bw_data = SRC_H;
                c.done  = 1'b1; c.res = RES_NONE;
            end
            // Insert at head: a = fwd[h]; bwd[a] = n; fwd[n] = a; bwd[n] = h; fwd[h] = n.
            UPC_INSH0: begin
                c.fr_addr = SRC_H;
                c.iw_en   = 1'b1;
            end
            UPC_INSH1: begin
                c.bw_en = 1'b1; c.bw_addr = SRC_FRD; c.bw_data = SRC_N;
                c.fw_en = 1'b1; c.fw_addr = SRC_N;   c.fw_data = SRC_FRD;
            end
            UPC_INSH2: begin
                c.bw_en = 1'b1; c.bw_addr = SRC_N; c.bw_data = SRC_H;
                c.fw_en = 1'b1; c.fw_addr = SRC_H; c.fw_data = SRC_N;
                c.done  = 1'b1; c.res = RES_NONE;
            end
            // Insert at tail: a = bwd[h]; fwd[n] = h; bwd[n] = a; bwd[h] = n; fwd[a] = n.
            UPC_INST0: begin
                c.br_addr = SRC_H;
                c.iw_en   = 1'b1;
            end
            UPC_INST1: begin
                c.fw_en = 1'b1; c.fw_addr = SRC_N; c.fw_data = SRC_H;
                c.bw_en = 1'b1; c.bw_addr = SRC_N; c.bw_data = SRC_BRD;
                c.ld_a  = 1'b1; c.a_src = SRC_BRD;
            end
            UPC_INST2: begin
                c.bw_en = 1'b1; c.bw_addr = SRC_H; c.bw_data = SRC_N;
                c.fw_en = 1'b1; c.fw_addr = SRC_A; c.fw_data = SRC_N;
                c.done  = 1'b1; c.res = RES_NONE;
            end
            // Pop head: a = fwd[h]; b = fwd[a]; fwd[h] = b; bwd[b] = h; detach a.
            UPC_POPH0: begin
                c.fr_addr = SRC_H;
            end
            UPC_POPH1: begin
                c.jmp_en  = 1'b1; c.cmp_src = SRC_H; c.jmp_to = UPC_EMPTY;
                c.ld_a    = 1'b1; c.a_src = SRC_FRD;
                c.fr_addr = SRC_FRD;
                c.ir_addr = SRC_FRD;
            end
            UPC_POPH2: begin
                c.fw_en    = 1'b1; c.fw_addr = SRC_H;   c.fw_data = SRC_FRD;
                c.bw_en    = 1'b1; c.bw_addr = SRC_FRD; c.bw_data = SRC_H;
                c.item_cap = 1'b1;
            end
            UPC_POPH3: begin
                c.fw_en = 1'b1; c.fw_addr = SRC_A; c.fw_data = SRC_A;
                c.bw_en = 1'b1; c.bw_addr = SRC_A; c.bw_data = SRC_A;
                c.done  = 1'b1; c.res = RES_POP;
            end
            // Pop tail: empty test on fwd[h]; a = bwd[h]; b = bwd[a]; bwd[h] = b; fwd[b] = h.
            UPC_POPT0: begin
                c.fr_addr = SRC_H;
                c.br_addr = SRC_H;
            end
            UPC_POPT1: begin
                c.jmp_en  = 1'b1; c.cmp_src = SRC_H; c.jmp_to = UPC_EMPTY;
                c.ld_a    = 1'b1; c.a_src = SRC_BRD;
                c.br_addr = SRC_BRD;
                c.ir_addr = SRC_BRD;
            end
            UPC_POPT2: begin
                c.bw_en    = 1'b1; c.bw_addr = SRC_H;   c.bw_data = SRC_BRD;
                c.fw_en    = 1'b1; c.fw_addr = SRC_BRD; c.fw_data = SRC_H;
                c.item_cap = 1'b1;
            end
            UPC_POPT3: begin
                c.fw_en = 1'b1; c.fw_addr = SRC_A; c.fw_data = SRC_A;
                c.bw_en = 1'b1; c.bw_addr = SRC_A; c.bw_data = SRC_A;
                c.done  = 1'b1; c.res = RES_POP;
            end
            // Remove node: refuse a self-linked node; a = bwd[n]; b = fwd[n]; detach n;
            // fwd[a] = b; bwd[b] = a.
            UPC_REM0: begin
                c.fr_addr = SRC_N;
                c.br_addr = SRC_N;
                c.ir_addr = SRC_N;
            end
            UPC_REM1: begin
                c.jmp_en   = 1'b1; c.cmp_src = SRC_N; c.jmp_to = UPC_REFUSE;
                c.ld_a     = 1'b1; c.a_src = SRC_BRD;
                c.ld_b     = 1'b1; c.b_src = SRC_FRD;
                c.item_cap = 1'b1;
            end
            UPC_REM2: begin
                c.fw_en = 1'b1; c.fw_addr = SRC_N; c.fw_data = SRC_N;
                c.bw_en = 1'b1; c.bw_addr = SRC_N; c.bw_data = SRC_N;
            end
            UPC_REM3: begin
                c.fw_en = 1'b1; c.fw_addr = SRC_A; c.fw_data = SRC_B;
                c.bw_en = 1'b1; c.bw_addr = SRC_B; c.bw_data = SRC_A;
                c.done  = 1'b1; c.res = RES_REM;
            end
            // Remove section: a = bwd[n]; b = fwd[e]; fwd[a] = b; bwd[b] = a.
            UPC_SEC0: begin
                c.br_addr = SRC_N;
                c.fr_addr = SRC_E;
            end
            UPC_SEC1: begin
                c.fw_en = 1'b1; c.fw_addr = SRC_BRD; c.fw_data = SRC_FRD;
                c.bw_en = 1'b1; c.bw_addr = SRC_FRD; c.bw_data = SRC_BRD;
                c.done  = 1'b1; c.res = RES_NONE;
            end
            UPC_EMPTY: begin
                c.done = 1'b1; c.res = RES_EMPTY;
            end
            UPC_REFUSE: begin
                c.done = 1'b1; c.res = RES_REFUSE;
            end
            default: begin
                c.done = 1'b1; c.res = RES_NONE;
            end
        endcase
        return c;
    endfunction

endpackage

// ----- design/dlle_datapath.sv -----
// Node memories, operand registers and result forming of the list engine.
module dlle_datapath #(
    parameter int NODE_COUNT = dlle_pkg::NODE_COUNT_DEF,
    parameter int ITEM_BITS  = dlle_pkg::ITEM_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_load,
    input  dlle_pkg::t_in_item  i_item,
    input  dlle_pkg::t_ctl      i_ctl,
    output dlle_pkg::t_dp_stat  o_stat,
    output dlle_pkg::t_out_item o_res
);

    localparam int IDX_W = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;

    // Reciprocal of the pool size, scaled so that the quotient of any index is exact.
    localparam int RECIP_SH = 2 * dlle_pkg::IN_IDX_W;
    localparam int RECIP_W  = RECIP_SH + 1;
    localparam int PROD_W   = RECIP_W + dlle_pkg::IN_IDX_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << RECIP_SH) + 64'(NODE_COUNT) - 64'd1) / 64'(NODE_COUNT));

    typedef logic [IDX_W-1:0] t_idx;

    // Node memories.
    t_idx                 r_fwd_mem  [NODE_COUNT];
    t_idx                 r_bwd_mem  [NODE_COUNT];
    logic [ITEM_BITS-1:0] r_item_mem [NODE_COUNT];

    // Held command operands and working registers.
    t_idx                 r_h, r_n, r_e, r_a, r_b;
    t_idx                 r_frd, r_brd;
    logic [ITEM_BITS-1:0] r_pay, r_ird, r_item;

    t_idx fr_addr, br_addr, ir_addr, fw_addr, fw_data, bw_addr, bw_data;

    // Reduces an index modulo the pool size: quotient by reciprocal multiplication,
    // then one multiply and subtract for the remainder.
    function automatic t_idx pool_index(input logic [dlle_pkg::IN_IDX_W-1:0] v);
        logic [PROD_W-1:0]               prod;
        logic [dlle_pkg::IN_IDX_W-1:0]   q;
        logic [31:0]                     rem;
        prod = PROD_W'(v) * PROD_W'(RECIP);
        q    = prod[RECIP_SH +: dlle_pkg::IN_IDX_W];
        rem  = 32'(v) - 32'(q) * 32'(NODE_COUNT);
        return rem[IDX_W-1:0];
    endfunction

    // Operand selection.
    function automatic t_idx pick(input dlle_pkg::t_src s);
        t_idx v;
        case (s)
            dlle_pkg::SRC_H:   v = r_h;
            dlle_pkg::SRC_N:   v = r_n;
            dlle_pkg::SRC_E:   v = r_e;
            dlle_pkg::SRC_A:   v = r_a;
            dlle_pkg::SRC_B:   v = r_b;
            dlle_pkg::SRC_FRD: v = r_frd;
            dlle_pkg::SRC_BRD: v = r_brd;
            default:           v = '0;
        endcase
        return v;
    endfunction

    always_comb begin
        fr_addr = pick(i_ctl.fr_addr);
        br_addr = pick(i_ctl.br_addr);
        ir_addr = pick(i_ctl.ir_addr);
        fw_addr = pick(i_ctl.fw_addr);
        fw_data = pick(i_ctl.fw_data);
        bw_addr = pick(i_ctl.bw_addr);
        bw_data = pick(i_ctl.bw_data);
    end

    // Capture the command operands when an item is accepted.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_h   <= pool_index(i_item.list_head);
            r_n   <= pool_index(i_item.node_index);
            r_e   <= pool_index(i_item.section_end);
            r_pay <= ITEM_BITS'(i_item.payload);
        end
    end

    // Memory writes.
    always_ff @(posedge i_clk) begin
        if (i_ctl.fw_en) begin
            r_fwd_mem[fw_addr] <= fw_data;
        end
        if (i_ctl.bw_en) begin
            r_bwd_mem[bw_addr] <= bw_data;
        end
        if (i_ctl.iw_en) begin
            r_item_mem[r_n] <= r_pay;
        end
    end

    // Registered memory reads; the data is used by the next step.
    always_ff @(posedge i_clk) begin
        r_frd <= r_fwd_mem[fr_addr];
        r_brd <= r_bwd_mem[br_addr];
        r_ird <= r_item_mem[ir_addr];
    end

    // Link and item registers.
    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_a) begin
            r_a <= pick(i_ctl.a_src);
        end
        if (i_ctl.ld_b) begin
            r_b <= pick(i_ctl.b_src);
        end
        if (i_ctl.item_cap) begin
            r_item <= r_ird;
        end
    end

    // Condition for the sequencer's jump: forward read data against an operand.
    always_comb begin
        o_stat.src_eq = (r_frd == pick(i_ctl.cmp_src));
    end

    // Result item of the final step.
    always_comb begin
        o_res = '0;
        case (i_ctl.res)
            dlle_pkg::RES_POP: begin
                o_res.item_out = dlle_pkg::PAY_W'(r_item);
                o_res.node_out = dlle_pkg::IN_IDX_W'(r_a);
                o_res.status   = dlle_pkg::ST_OK;
            end
            dlle_pkg::RES_REM: begin
                o_res.item_out = dlle_pkg::PAY_W'(r_item);
                o_res.node_out = dlle_pkg::IN_IDX_W'(r_n);
                o_res.status   = dlle_pkg::ST_OK;
            end
            dlle_pkg::RES_EMPTY: begin
                o_res.status = dlle_pkg::ST_EMPTY;
            end
            dlle_pkg::RES_REFUSE: begin
                o_res.status = dlle_pkg::ST_REFUSED;
            end
            default: begin
                o_res.status = dlle_pkg::ST_OK;
            end
        endcase
    end

endmodule

// ----- design/dlle_sequencer.sv -----
// Microcode sequencer and result register of the list engine.
module dlle_sequencer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [dlle_pkg::CMD_W-1:0] i_cmd,
    output logic                o_load,
    output dlle_pkg::t_ctl      o_ctl,
    input  dlle_pkg::t_dp_stat  i_stat,
    input  dlle_pkg::t_out_item i_res,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output dlle_pkg::t_out_item o_out_item
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_HOLD = 3'b100
    } t_state;

    t_state              r_state, n_state;
    dlle_pkg::t_upc      r_pc, n_pc;
    logic                r_ovalid, n_ovalid;
    dlle_pkg::t_out_item r_out, n_out;
    dlle_pkg::t_out_item r_pend, n_pend;

    logic out_free;

    // Current control word; outside a program every enable is off.
    assign o_ctl      = (r_state == S_RUN) ? dlle_pkg::ucode(r_pc) : dlle_pkg::CTL_NOP;
    assign o_in_ready = (r_state == S_IDLE);
    assign o_load     = o_in_ready && i_in_valid;
    assign out_free   = !r_ovalid || i_out_ready;

    // Step counter, jumps and the hand-off of the result.
    always_comb begin
        n_state  = r_state;
        n_pc     = r_pc;
        n_ovalid = r_ovalid && !i_out_ready;
        n_out    = r_out;
        n_pend   = r_pend;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_pc    = dlle_pkg::entry_point(i_cmd);
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (o_ctl.done) begin
                    if (out_free) begin
                        n_out    = i_res;
                        n_ovalid = 1'b1;
                        n_state  = S_IDLE;
                    end else begin
                        n_pend  = i_res;
                        n_state = S_HOLD;
                    end
                end else if (o_ctl.jmp_en && i_stat.src_eq) begin
                    n_pc = o_ctl.jmp_to;
                end else begin
                    n_pc = r_pc + 1'b1;
                end
            end
            S_HOLD: begin
                if (out_free) begin
                    n_out    = r_pend;
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_pc   <= n_pc;
        r_out  <= n_out;
        r_pend <= n_pend;
    end

    assign o_out_valid = r_ovalid;
    assign o_out_item  = r_out;

endmodule

// ----- design/doubly_linked_list_engine_top.sv -----
// Top level of the doubly linked list engine.
// Holds a pool of NODE_COUNT list nodes (forward link, backward link, item) in three
// single-port-write memories and runs one command at a time from a microcode program.
// A command runs its program step by step; pop head or tail ends early when the list is
// empty and remove node ends early when it is refused. After the last step the engine
// returns to idle and takes the next item from there. Program length is set by the one
// write port per link memory and the registered read of each link. The result of an item
// goes to an output register when that is free, else first to a pending register, and
// waits there; a new item is taken while it waits in the output register, not while pending.
// Node memories are not cleared at reset; a node must be written before it is read.
module doubly_linked_list_engine_top #(
    parameter int NODE_COUNT = dlle_pkg::NODE_COUNT_DEF,
    parameter int ITEM_BITS  = dlle_pkg::ITEM_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  dlle_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output dlle_pkg::t_out_item o_out_item
);

    logic                load;
    dlle_pkg::t_ctl      ctl;
    dlle_pkg::t_dp_stat  stat;
    dlle_pkg::t_out_item res;

    // Program sequencing and the output channel.
    dlle_sequencer u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_cmd       (i_in_item.cmd),
        .o_load      (load),
        .o_ctl       (ctl),
        .i_stat      (stat),
        .i_res       (res),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    // Node memories and operands.
    dlle_datapath #(
        .NODE_COUNT (NODE_COUNT),
        .ITEM_BITS  (ITEM_BITS)
    ) u_dp (
        .i_clk  (i_clk),
        .i_load (load),
        .i_item (i_in_item),
        .i_ctl  (ctl),
        .o_stat (stat),
        .o_res  (res)
    );

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench of the doubly linked list engine: node pool prediction and list traffic.
`timescale 1ns / 100ps

module tb;

    // Code that the engine takes but does nothing with.
    localparam logic [dlle_pkg::CMD_W-1:0] CMD_UNUSED = 3'd7;

    localparam int POOL_SIZE    = dlle_pkg::NODE_COUNT_DEF;
    localparam int RANDOM_ITEMS = 1070;
    localparam int MAX_LISTS    = 4;
    localparam int WALK_MAX     = 64;
    localparam int PRINT_MAX    = 50;

    // One row of the directed script.
    typedef struct {
        dlle_pkg::t_in_item  cmd;
        bit                  typed;
        dlle_pkg::t_out_item want;
    } t_script_row;

    logic                clk;
    logic                rst_n;
    logic                cmd_valid;
    logic                cmd_ready;
    dlle_pkg::t_in_item  cmd_item;
    logic                res_valid;
    logic                res_ready;
    dlle_pkg::t_out_item res_item;

    // Predicted node pool, with a flag per entry once it holds a written value.
    bit [dlle_pkg::IN_IDX_W-1:0] fwd_link [POOL_SIZE];
    bit [dlle_pkg::IN_IDX_W-1:0] bwd_link [POOL_SIZE];
    bit [dlle_pkg::PAY_W-1:0]    node_val [POOL_SIZE];
    bit                          fwd_set  [POOL_SIZE];
    bit                          bwd_set  [POOL_SIZE];
    bit                          val_set  [POOL_SIZE];

    // Results predicted for accepted commands, oldest first.
    dlle_pkg::t_out_item pending_results[$];

    // Lists that the traffic works on, and nodes that are linked into them.
    logic [dlle_pkg::IN_IDX_W-1:0] sentinel [MAX_LISTS];
    int                            n_sent;
    bit                            in_use [POOL_SIZE];

    // Directed script and the expectation typed for the command now on offer.
    t_script_row         script[$];
    bit                  typed_pending;
    dlle_pkg::t_out_item typed_want;

    bit send_calm;
    bit recv_calm;
    int mismatch_count;

    doubly_linked_list_engine_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (cmd_valid),
        .o_in_ready  (cmd_ready),
        .i_in_item   (cmd_item),
        .o_out_valid (res_valid),
        .i_out_ready (res_ready),
        .o_out_item  (res_item)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Run limit, far beyond the slowest legal run.
    initial begin
        #1_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    function automatic int idle_cycles(input bit calm);
        return calm ? 0 : int'($urandom_range(0, 16));
    endfunction

    function automatic logic [dlle_pkg::PAY_W-1:0] rand_payload();
        int pick;
        pick = $urandom_range(0, 7);
        if (pick == 0) begin
            return '0;
        end
        if (pick == 1) begin
            return '1;
        end
        return dlle_pkg::PAY_W'($urandom);
    endfunction

    function automatic t_script_row script_row(input logic [dlle_pkg::CMD_W-1:0] cmd,
                                               input logic [dlle_pkg::IN_IDX_W-1:0] h,
                                               input logic [dlle_pkg::IN_IDX_W-1:0] n,
                                               input logic [dlle_pkg::IN_IDX_W-1:0] e,
                                               input logic [dlle_pkg::PAY_W-1:0] pay,
                                               input bit typed,
                                               input logic [dlle_pkg::PAY_W-1:0] w_item,
                                               input logic [dlle_pkg::IN_IDX_W-1:0] w_node,
                                               input logic [dlle_pkg::STAT_W-1:0] w_status);
        t_script_row r;
        r.cmd.cmd         = cmd;
        r.cmd.list_head   = h;
        r.cmd.node_index  = n;
        r.cmd.section_end = e;
        r.cmd.payload     = pay;
        r.typed           = typed;
        r.want.item_out   = w_item;
        r.want.node_out   = w_node;
        r.want.status     = w_status;
        return r;
    endfunction

    function automatic void link_fwd(input logic [dlle_pkg::IN_IDX_W-1:0] idx,
                                     input logic [dlle_pkg::IN_IDX_W-1:0] val);
        fwd_link[idx] = val;
        fwd_set[idx]  = 1'b1;
    endfunction

    function automatic void link_bwd(input logic [dlle_pkg::IN_IDX_W-1:0] idx,
                                     input logic [dlle_pkg::IN_IDX_W-1:0] val);
        bwd_link[idx] = val;
        bwd_set[idx]  = 1'b1;
    endfunction

    // Applies one command to the predicted pool and returns the result it gives.
    function automatic dlle_pkg::t_out_item advance_pool(input dlle_pkg::t_in_item c);
        logic [dlle_pkg::IN_IDX_W-1:0] h, n, e, a, b;
        dlle_pkg::t_out_item r;
        h = c.list_head;
        n = c.node_index;
        e = c.section_end;
        r = '0;
        case (c.cmd)
            dlle_pkg::CMD_INIT: begin
                link_fwd(h, h);
                link_bwd(h, h);
            end
            dlle_pkg::CMD_INS_HEAD: begin
                node_val[n] = c.payload;
                val_set[n]  = 1'b1;
                a = fwd_link[h];
                link_bwd(a, n);
                link_fwd(n, a);
                link_bwd(n, h);
                link_fwd(h, n);
            end
            dlle_pkg::CMD_INS_TAIL: begin
                node_val[n] = c.payload;
                val_set[n]  = 1'b1;
                a = bwd_link[h];
                link_fwd(n, h);
                link_bwd(n, a);
                link_bwd(h, n);
                link_fwd(a, n);
            end
            dlle_pkg::CMD_POP_HEAD, dlle_pkg::CMD_POP_TAIL: begin
                if (fwd_link[h] == h) begin
                    r.status = dlle_pkg::ST_EMPTY;
                end else if (c.cmd == dlle_pkg::CMD_POP_HEAD) begin
                    a = fwd_link[h];
                    b = fwd_link[a];
                    link_fwd(h, b);
                    link_bwd(b, h);
                end else begin
                    a = bwd_link[h];
                    b = bwd_link[a];
                    link_bwd(h, b);
                    link_fwd(b, h);
                end
                if (r.status != dlle_pkg::ST_EMPTY) begin
                    r.item_out = node_val[a];
                    r.node_out = a;
                    link_fwd(a, a);
                    link_bwd(a, a);
                end
            end
            dlle_pkg::CMD_REM_NODE: begin
                if (fwd_link[n] == n) begin
                    r.status = dlle_pkg::ST_REFUSED;
                end else begin
                    a = bwd_link[n];
                    b = fwd_link[n];
                    link_fwd(n, n);
                    link_bwd(n, n);
                    link_fwd(a, b);
                    link_bwd(b, a);
                    r.item_out = node_val[n];
                    r.node_out = n;
                end
            end
            dlle_pkg::CMD_REM_SECT: begin
                a = bwd_link[n];
                b = fwd_link[e];
                link_fwd(a, b);
                link_bwd(b, a);
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    // True when every pool entry that the command may read has been written.
    function automatic bit pool_reads_ok(input dlle_pkg::t_in_item c);
        logic [dlle_pkg::IN_IDX_W-1:0] h, n, e, a;
        bit ok;
        h = c.list_head;
        n = c.node_index;
        e = c.section_end;
        ok = 1'b1;
        case (c.cmd)
            dlle_pkg::CMD_INS_HEAD: ok = fwd_set[h];
            dlle_pkg::CMD_INS_TAIL: ok = bwd_set[h];
            dlle_pkg::CMD_POP_HEAD: begin
                a = fwd_link[h];
                ok = fwd_set[h] && fwd_set[a] && val_set[a];
            end
            dlle_pkg::CMD_POP_TAIL: begin
                a = bwd_link[h];
                ok = fwd_set[h] && bwd_set[h] && bwd_set[a] && val_set[a];
            end
            dlle_pkg::CMD_REM_NODE: ok = fwd_set[n] && bwd_set[n] && val_set[n];
            dlle_pkg::CMD_REM_SECT: ok = bwd_set[n] && fwd_set[e];
            default:                ok = 1'b1;
        endcase
        return ok;
    endfunction

    // Builds a command that keeps one of the active lists well formed.
    function automatic dlle_pkg::t_in_item shaped_cmd();
        dlle_pkg::t_in_item c;
        logic [dlle_pkg::IN_IDX_W-1:0] s, walk, free_node;
        logic [dlle_pkg::IN_IDX_W-1:0] members [WALK_MAX];
        int len, pick, i, j, k, tries;
        bit found;
        s = sentinel[$urandom_range(0, n_sent - 1)];
        len = 0;
        walk = fwd_link[s];
        while (walk != s && len < WALK_MAX) begin
            members[len] = walk;
            len++;
            walk = fwd_link[walk];
        end
        c.cmd         = dlle_pkg::CMD_POP_HEAD;
        c.list_head   = s;
        c.node_index  = dlle_pkg::IN_IDX_W'($urandom);
        c.section_end = dlle_pkg::IN_IDX_W'($urandom);
        c.payload     = rand_payload();
        pick = $urandom_range(0, 99);
        // Long lists lean toward removals.
        if (len > 20 && pick < 40) begin
            pick = pick + 40;
        end
        if (pick < 40) begin
            found = 1'b0;
            for (tries = 0; tries < 64 && !found; tries++) begin
                free_node = dlle_pkg::IN_IDX_W'($urandom_range(0, POOL_SIZE - 1));
                found = !in_use[free_node];
            end
            if (found) begin
                c.cmd = (pick < 20) ? dlle_pkg::CMD_INS_HEAD : dlle_pkg::CMD_INS_TAIL;
                c.node_index = free_node;
                in_use[free_node] = 1'b1;
            end
        end else if (pick < 70) begin
            c.cmd = (pick < 55) ? dlle_pkg::CMD_POP_HEAD : dlle_pkg::CMD_POP_TAIL;
            if (len > 0) begin
                in_use[(pick < 55) ? members[0] : members[len - 1]] = 1'b0;
            end
        end else if (pick < 88) begin
            // List head is random here since removal does not use it.
            c.cmd = dlle_pkg::CMD_REM_NODE;
            c.list_head = dlle_pkg::IN_IDX_W'($urandom);
            if (len == 0) begin
                c.node_index = s;
            end else begin
                i = $urandom_range(0, len - 1);
                c.node_index = members[i];
                in_use[members[i]] = 1'b0;
            end
        end else if (len > 0) begin
            c.cmd = dlle_pkg::CMD_REM_SECT;
            i = $urandom_range(0, len - 1);
            j = $urandom_range(i, len - 1);
            c.node_index  = members[i];
            c.section_end = members[j];
            for (k = i; k <= j; k++) begin
                in_use[members[k]] = 1'b0;
            end
        end
        return c;
    endfunction

    // Any command, with the list head often one of the active sentinels.
    function automatic dlle_pkg::t_in_item noise_cmd();
        dlle_pkg::t_in_item c;
        c.cmd         = dlle_pkg::CMD_W'($urandom_range(0, 7));
        c.list_head   = ($urandom_range(0, 1) == 1) ? sentinel[$urandom_range(0, n_sent - 1)]
                                                    : dlle_pkg::IN_IDX_W'($urandom);
        c.node_index  = dlle_pkg::IN_IDX_W'($urandom);
        c.section_end = dlle_pkg::IN_IDX_W'($urandom);
        c.payload     = rand_payload();
        return c;
    endfunction

    task automatic flag_mismatch(input string what, input logic [dlle_pkg::PAY_W-1:0] got,
                                 input logic [dlle_pkg::PAY_W-1:0] want);
        mismatch_count++;
        if (mismatch_count <= PRINT_MAX) begin
            $display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want);
        end
    endtask

    // Offers one command, after a random gap unless calm, and returns at the falling edge once taken.
    task automatic push_cmd(input dlle_pkg::t_in_item c, input bit typed,
                            input dlle_pkg::t_out_item want);
        int gap;
        gap = idle_cycles(send_calm);
        typed_pending = typed;
        typed_want    = want;
        if (gap > 0) begin
            cmd_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_item  <= c;
        do @(posedge clk); while (cmd_ready !== 1'b1);
        @(negedge clk);
    endtask

    // Both handshakes are observed here so that results and predictions keep a fixed order.
    always @(posedge clk) begin : watch_channels
        dlle_pkg::t_out_item want;
        dlle_pkg::t_out_item got;
        if (rst_n) begin
            if (res_valid && res_ready) begin
                if (pending_results.size() == 0) begin
                    flag_mismatch("result item with nothing pending",
                                  dlle_pkg::PAY_W'(res_item.node_out), '0);
                end else begin
                    want = pending_results.pop_front();
                    if (res_item.item_out !== want.item_out) begin
                        flag_mismatch("item_out", res_item.item_out, want.item_out);
                    end
                    if (res_item.node_out !== want.node_out) begin
                        flag_mismatch("node_out", dlle_pkg::PAY_W'(res_item.node_out),
                                      dlle_pkg::PAY_W'(want.node_out));
                    end
                    if (res_item.status !== want.status) begin
                        flag_mismatch("status", dlle_pkg::PAY_W'(res_item.status),
                                      dlle_pkg::PAY_W'(want.status));
                    end
                end
            end
            if (cmd_valid && cmd_ready) begin
                got = advance_pool(cmd_item);
                pending_results.push_back(typed_pending ? typed_want : got);
            end
        end
    end

    // Result side: a random stall before each item is taken, unless receiving is calm.
    initial begin : result_sink
        int stall;
        res_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            stall = idle_cycles(recv_calm);
            if (stall > 0) begin
                @(negedge clk);
                res_ready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk);
            res_ready <= 1'b1;
            do @(posedge clk); while (res_valid !== 1'b1);
        end
    end

    // Command side: reset, the directed script, then list traffic in phases.
    initial begin : stimulus
        dlle_pkg::t_in_item            c;
        logic [dlle_pkg::IN_IDX_W-1:0] s;
        int                            k, tries, sent;
        rst_n          = 1'b0;
        cmd_valid      = 1'b0;
        cmd_item       = '0;
        typed_pending  = 1'b0;
        typed_want     = '0;
        send_calm      = 1'b0;
        recv_calm      = 1'b0;
        mismatch_count = 0;
        n_sent         = 1;
        sentinel[0]    = '0;

        // Sentinel 1023 hands node 0 an item so that node 0 is fully written as a sentinel.
        script.push_back(script_row(dlle_pkg::CMD_INIT, 10'h3FF, 10'h000, 10'h000, 32'h0,
                                    1'b1, 32'h0, 10'h0, dlle_pkg::ST_OK));
        script.push_back(script_row(dlle_pkg::CMD_INS_HEAD, 10'h3FF, 10'h000, 10'h3FF,
                                    32'hFFFF_FFFF, 1'b1, 32'h0, 10'h0, dlle_pkg::ST_OK));
        script.push_back(script_row(dlle_pkg::CMD_POP_HEAD, 10'h3FF, 10'h000, 10'h000, 32'h0,
                                    1'b1, 32'hFFFF_FFFF, 10'h000, dlle_pkg::ST_OK));
        script.push_back(script_row(dlle_pkg::CMD_INIT, 10'h000, 10'h3FF, 10'h3FF,
                                    32'hFFFF_FFFF, 1'b1, 32'h0, 10'h0, dlle_pkg::ST_OK));
        // Empty list from both ends, then removal of a self-linked sentinel.
        script.push_back(script_row(dlle_pkg::CMD_POP_HEAD, 10'h000, 10'h000, 10'h000, 32'h0,
                                    1'b1, 32'h0, 10'h0, dlle_pkg::ST_EMPTY));
        script.push_back(script_row(dlle_pkg::CMD_POP_TAIL, 10'h000, 10'h3FF, 10'h000, 32'h0,
                                    1'b1, 32'h0, 10'h0, dlle_pkg::ST_EMPTY));
        script.push_back(script_row(dlle_pkg::CMD_REM_NODE, 10'h3FF, 10'h000, 10'h000, 32'h0,
                                    1'b1, 32'h0, 10'h0, dlle_pkg::ST_REFUSED));
        // Build a list on sentinel 0 from both ends.
        script.push_back(script_row(dlle_pkg::CMD_INS_TAIL, 10'h000, 10'h3FF, 10'h000, 32'h0,
                                    1'b0, '0, '0, '0));
        script.push_back(script_row(dlle_pkg::CMD_INS_HEAD, 10'h000, 10'h155, 10'h2AA,
                                    32'hA5A5_A5A5, 1'b0, '0, '0, '0));
        script.push_back(script_row(dlle_pkg::CMD_INS_TAIL, 10'h000, 10'h2AA, 10'h155,
                                    32'h5A5A_5A5A, 1'b0, '0, '0, '0));
        script.push_back(script_row(dlle_pkg::CMD_INS_HEAD, 10'h000, 10'h001, 10'h000, 32'h1,
                                    1'b0, '0, '0, '0));
        script.push_back(script_row(dlle_pkg::CMD_POP_TAIL, 10'h000, 10'h000, 10'h000, 32'h0,
                                    1'b0, '0, '0, '0));
        // Removal ignores the list head; a detached node is then refused.
        script.push_back(script_row(dlle_pkg::CMD_REM_NODE, 10'h3FF, 10'h155, 10'h000, 32'h0,
                                    1'b0, '0, '0, '0));
        script.push_back(script_row(dlle_pkg::CMD_REM_NODE, 10'h000, 10'h155, 10'h3FF, 32'h0,
                                    1'b1, 32'h0, 10'h0, dlle_pkg::ST_REFUSED));
        script.push_back(script_row(dlle_pkg::CMD_INS_TAIL, 10'h000, 10'h2AA, 10'h000,
                                    32'h1234_5678, 1'b0, '0, '0, '0));
        script.push_back(script_row(dlle_pkg::CMD_INS_TAIL, 10'h000, 10'h155, 10'h000,
                                    32'h8765_4321, 1'b0, '0, '0, '0));
        // Cut the run from node 1 through node 2AA, leaving only node 155.
        script.push_back(script_row(dlle_pkg::CMD_REM_SECT, 10'h000, 10'h001, 10'h2AA, 32'h0,
                                    1'b1, 32'h0, 10'h0, dlle_pkg::ST_OK));
        script.push_back(script_row(dlle_pkg::CMD_POP_HEAD, 10'h000, 10'h000, 10'h000, 32'h0,
                                    1'b0, '0, '0, '0));
        script.push_back(script_row(dlle_pkg::CMD_POP_HEAD, 10'h000, 10'h000, 10'h000, 32'h0,
                                    1'b1, 32'h0, 10'h0, dlle_pkg::ST_EMPTY));
        script.push_back(script_row(CMD_UNUSED, 10'h3FF, 10'h3FF, 10'h3FF, 32'hFFFF_FFFF,
                                    1'b1, 32'h0, 10'h0, dlle_pkg::ST_OK));
        // The same node inserted twice leaves the links inconsistent.
        script.push_back(script_row(dlle_pkg::CMD_INS_HEAD, 10'h000, 10'h3FF, 10'h000, 32'h7,
                                    1'b0, '0, '0, '0));
        script.push_back(script_row(dlle_pkg::CMD_INS_HEAD, 10'h000, 10'h3FF, 10'h000, 32'h8,
                                    1'b0, '0, '0, '0));
        script.push_back(script_row(dlle_pkg::CMD_POP_TAIL, 10'h000, 10'h000, 10'h000, 32'h0,
                                    1'b0, '0, '0, '0));
        script.push_back(script_row(dlle_pkg::CMD_POP_HEAD, 10'h000, 10'h000, 10'h000, 32'h0,
                                    1'b0, '0, '0, '0));

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (script[i]) begin
            push_cmd(script[i].cmd, script[i].typed, script[i].want);
        end

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            // Let every pending result drain before new lists are set up.
            cmd_valid <= 1'b0;
            @(negedge clk);
            while (pending_results.size() != 0) @(negedge clk);
            send_calm = ($urandom_range(0, 3) == 0);
            recv_calm = ($urandom_range(0, 3) == 0);
            for (k = 0; k < POOL_SIZE; k++) begin
                in_use[k] = 1'b0;
            end

            // Fresh sentinels; a self insert gives each one a written item.
            n_sent = $urandom_range(1, MAX_LISTS);
            for (k = 0; k < n_sent; k++) begin
                do s = dlle_pkg::IN_IDX_W'($urandom_range(0, POOL_SIZE - 1)); while (in_use[s]);
                in_use[s]   = 1'b1;
                sentinel[k] = s;
                c = '0;
                c.cmd       = dlle_pkg::CMD_INIT;
                c.list_head = s;
                push_cmd(c, 1'b0, '0);
                c.cmd        = dlle_pkg::CMD_INS_HEAD;
                c.node_index = s;
                c.payload    = rand_payload();
                push_cmd(c, 1'b0, '0);
                sent += 2;
            end

            // Mostly well-formed list traffic, with some arbitrary commands mixed in.
            repeat ($urandom_range(40, 120)) begin
                if ($urandom_range(0, 99) < 85) begin
                    c = shaped_cmd();
                end else begin
                    c = noise_cmd();
                end
                tries = 0;
                while (!pool_reads_ok(c) && tries < 200) begin
                    c = noise_cmd();
                    tries++;
                end
                if (!pool_reads_ok(c)) begin
                    c.cmd = dlle_pkg::CMD_INIT;
                end
                push_cmd(c, 1'b0, '0);
                if (c.cmd != CMD_UNUSED) begin
                    sent++;
                end
            end
        end

        // Drain, then wait for anything unexpected to show up.
        cmd_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
        repeat (20) @(posedge clk);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
